### design/qsps_pkg.sv
package qsps_pkg;

    // Input word: one raw byte of the request line
    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_last;
    } line_word_t;

    typedef enum logic [1:0] {
        KIND_KEY_BYTE   = 2'd0,
        KIND_KEY_END    = 2'd1,
        KIND_VALUE_BYTE = 2'd2,
        KIND_PAIR_END   = 2'd3
    } kind_t;

    // Output word: one token of the pair stream
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       key_truncated;
        logic [7:0] pair_index;
        logic       run_last;
    } token_word_t;

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } esc_t;

    typedef enum logic [2:0] {
        SRC_STORE    = 3'd0,
        SRC_VALUE    = 3'd1,
        SRC_PCT      = 3'd2,
        SRC_HELD     = 3'd3,
        SRC_KEY_END  = 3'd4,
        SRC_PAIR_END = 3'd5
    } out_src_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [2:0] PREFIX_SKIP_RESET = 3'd2;
    localparam logic [7:0] PAIR_MAX          = 8'd255;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     content_en;
        logic     content_key;
        logic     load_skip;
        logic     dec_skip;
        logic     clear_key;
        logic     line_reset;
        logic     key_put_pct;
        logic     key_put_held;
        logic     esc_clear;
        logic     key_idx_clear;
        logic     key_idx_inc;
        logic     key_rd;
        logic     out_load;
        out_src_t out_src;
        logic     out_run_last;
        logic     pair_inc;
    } qsps_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_space;
        logic is_amp;
        logic is_eq;
        logic prefix_zero;
        logic skip_one;
        esc_t esc;
        logic content_delivers;
        logic key_done;
        logic out_free;
    } qsps_status_t;

endpackage

### design/qsps_datapath.sv
module qsps_datapath
    import qsps_pkg::*;
#(
    parameter int KEY_MAX = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  line_word_t   line_data,
    input  logic         cfg_valid,
    input  logic [2:0]   cfg_data,
    input  qsps_cmd_t    cmd,
    output qsps_status_t st,
    output logic         tok_valid,
    input  logic         tok_stall,
    output token_word_t  tok_data
);

    localparam int LEN_W = $clog2(KEY_MAX + 1);
    localparam int IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
        return r;
    endfunction

    function automatic logic [7:0] plus_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    logic [7:0]       key_store [KEY_MAX];
    logic [2:0]       prefix_reg;
    logic [2:0]       skip_reg;
    esc_t             esc_reg;
    logic [7:0]       held_reg;
    logic [LEN_W-1:0] key_len_reg;
    logic             ovf_reg;
    logic [7:0]       pair_reg;
    logic [LEN_W-1:0] key_idx_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       val_reg;
    logic             out_valid_reg;
    token_word_t      out_word_reg;

    logic [7:0]  b;
    logic [4:0]  d1;
    logic [4:0]  d2;
    logic [7:0]  esc_val;
    logic [7:0]  content_val;
    logic        content_delivers;
    logic        key_put;
    logic [7:0]  key_put_data;
    logic        key_room;
    token_word_t out_word_next;

    assign b  = line_data.line_byte;
    assign d1 = hex_of(held_reg);
    assign d2 = hex_of(b);

    always_comb
    begin
        if (d1[4])
            esc_val = 8'd0;
        else if (d2[4])
            esc_val = {4'd0, d1[3:0]};
        else
            esc_val = {d1[3:0], d2[3:0]};
    end

    assign content_val      = (esc_reg == ESC_DIGIT) ? esc_val : plus_map(b);
    assign content_delivers = ((esc_reg == ESC_IDLE) && (b != CH_PCT)) || (esc_reg == ESC_DIGIT);

    assign key_put = (cmd.content_en && cmd.content_key && content_delivers)
                   || cmd.key_put_pct || cmd.key_put_held;
    assign key_put_data = cmd.key_put_pct  ? CH_PCT :
                          cmd.key_put_held ? plus_map(held_reg) : content_val;
    assign key_room = key_len_reg < LEN_W'(KEY_MAX);

    // Status back to the controller
    assign st.is_space         = (b == CH_SPACE);
    assign st.is_amp           = (b == CH_AMP);
    assign st.is_eq            = (b == CH_EQ);
    assign st.prefix_zero      = (prefix_reg == 3'd0);
    assign st.skip_one         = (skip_reg == 3'd1);
    assign st.esc              = esc_reg;
    assign st.content_delivers = content_delivers;
    assign st.key_done         = (key_idx_reg == key_len_reg);
    assign st.out_free         = !out_valid_reg || !tok_stall;

    // Key buffer and payload holding registers
    always_ff @(posedge clk)
    begin
        if (key_put && key_room)
            key_store[key_len_reg[IDX_W-1:0]] <= key_put_data;
        if (cmd.key_rd)
            rd_data_reg <= key_store[key_idx_reg[IDX_W-1:0]];
        if (cmd.content_en && !cmd.content_key)
            val_reg <= content_val;
        if (cmd.out_load)
            out_word_reg <= out_word_next;
    end

    always_comb
    begin
        out_word_next.kind          = KIND_VALUE_BYTE;
        out_word_next.data_byte     = 8'd0;
        out_word_next.key_truncated = 1'b0;
        out_word_next.pair_index    = pair_reg;
        out_word_next.run_last      = cmd.out_run_last;
        unique case (cmd.out_src)
            SRC_STORE:
            begin
                out_word_next.kind      = KIND_KEY_BYTE;
                out_word_next.data_byte = rd_data_reg;
            end
            SRC_VALUE:    out_word_next.data_byte = val_reg;
            SRC_PCT:      out_word_next.data_byte = CH_PCT;
            SRC_HELD:     out_word_next.data_byte = plus_map(held_reg);
            SRC_KEY_END:
            begin
                out_word_next.kind          = KIND_KEY_END;
                out_word_next.key_truncated = ovf_reg;
            end
            SRC_PAIR_END: out_word_next.kind = KIND_PAIR_END;
            default:      out_word_next.kind = KIND_PAIR_END;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= PREFIX_SKIP_RESET;
            skip_reg      <= 3'd0;
            esc_reg       <= ESC_IDLE;
            held_reg      <= 8'd0;
            key_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            pair_reg      <= 8'd0;
            key_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                prefix_reg <= cfg_data;

            if (cmd.line_reset)
                skip_reg <= 3'd0;
            else if (cmd.load_skip)
                skip_reg <= prefix_reg;
            else if (cmd.dec_skip)
                skip_reg <= skip_reg - 3'd1;

            if (cmd.line_reset || cmd.clear_key || cmd.esc_clear)
            begin
                esc_reg  <= ESC_IDLE;
                held_reg <= 8'd0;
            end
            else if (cmd.content_en)
            begin
                unique case (esc_reg)
                    ESC_IDLE:
                    begin
                        if (b == CH_PCT)
                            esc_reg <= ESC_PCT;
                    end
                    ESC_PCT:
                    begin
                        held_reg <= b;
                        esc_reg  <= ESC_DIGIT;
                    end
                    ESC_DIGIT:
                    begin
                        held_reg <= 8'd0;
                        esc_reg  <= ESC_IDLE;
                    end
                    default: esc_reg <= ESC_IDLE;
                endcase
            end

            if (cmd.line_reset || cmd.clear_key)
            begin
                key_len_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            else if (key_put)
            begin
                if (key_room)
                    key_len_reg <= key_len_reg + LEN_W'(1);
                else
                    ovf_reg <= 1'b1;
            end

            if (cmd.line_reset)
                pair_reg <= 8'd0;
            else if (cmd.pair_inc && (pair_reg != PAIR_MAX))
                pair_reg <= pair_reg + 8'd1;

            if (cmd.key_idx_clear)
                key_idx_reg <= '0;
            else if (cmd.key_idx_inc)
                key_idx_reg <= key_idx_reg + LEN_W'(1);

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!tok_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign tok_valid = out_valid_reg;
    assign tok_data  = out_word_reg;

endmodule

### design/qsps_controller.sv
module qsps_controller
    import qsps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         line_valid,
    input  logic         line_last,
    output logic         line_stall,
    input  qsps_status_t st,
    output qsps_cmd_t    cmd
);

    typedef enum logic [4:0] {
        PH_SEEK  = 5'b00001,
        PH_SKIP  = 5'b00010,
        PH_KEY   = 5'b00100,
        PH_VALUE = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_FL1  = 8'b00000010,
        S_FL2  = 8'b00000100,
        S_KRD  = 8'b00001000,
        S_KOUT = 8'b00010000,
        S_KEND = 8'b00100000,
        S_VAL  = 8'b01000000,
        S_PEND = 8'b10000000
    } seq_state_t;

    phase_t     phase_reg, phase_next;
    seq_state_t state_reg, state_next;
    logic       plan_key_reg, plan_key_next;
    logic       plan_pair_reg, plan_pair_next;
    logic       plan_reset_reg, plan_reset_next;
    logic       seq_done;
    seq_state_t flush_target;

    assign line_stall   = (state_reg != S_IDLE);
    assign flush_target = plan_key_reg ? S_KRD : S_PEND;

    always_comb
    begin
        cmd             = '0;
        cmd.out_src     = SRC_VALUE;
        phase_next      = phase_reg;
        state_next      = state_reg;
        plan_key_next   = plan_key_reg;
        plan_pair_next  = plan_pair_reg;
        plan_reset_next = plan_reset_reg;
        seq_done        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (line_valid)
                begin
                    cmd.key_idx_clear = 1'b1;
                    plan_key_next     = 1'b0;
                    plan_pair_next    = 1'b0;
                    plan_reset_next   = 1'b0;
                    unique case (phase_reg)
                        PH_SEEK:
                        begin
                            if (st.is_space)
                            begin
                                cmd.load_skip = 1'b1;
                                cmd.clear_key = 1'b1;
                                phase_next    = st.prefix_zero ? PH_KEY : PH_SKIP;
                            end
                        end
                        PH_SKIP:
                        begin
                            cmd.dec_skip = 1'b1;
                            if (st.skip_one)
                                phase_next = PH_KEY;
                        end
                        PH_KEY:
                        begin
                            priority if (st.is_space)
                            begin
                                cmd.clear_key = 1'b1;
                                phase_next    = PH_DONE;
                            end
                            else if (st.is_amp)
                                cmd.clear_key = 1'b1;
                            else if (st.is_eq)
                            begin
                                plan_key_next  = 1'b1;
                                plan_pair_next = line_last;
                                phase_next     = PH_VALUE;
                                state_next     = S_FL1;
                            end
                            else
                            begin
                                cmd.content_en  = 1'b1;
                                cmd.content_key = 1'b1;
                            end
                        end
                        PH_VALUE:
                        begin
                            priority if (st.is_space)
                            begin
                                plan_pair_next = 1'b1;
                                phase_next     = PH_DONE;
                                state_next     = S_FL1;
                            end
                            else if (st.is_amp)
                            begin
                                plan_pair_next = 1'b1;
                                phase_next     = PH_KEY;
                                state_next     = S_FL1;
                            end
                            else
                            begin
                                cmd.content_en = 1'b1;
                                plan_pair_next = line_last;
                                if (st.content_delivers)
                                    state_next = S_VAL;
                                else if (line_last)
                                    state_next = S_FL1;
                            end
                        end
                        PH_DONE: ;
                        default: phase_next = PH_SEEK;
                    endcase
                    // Last byte: drop line state now, or after the burst
                    if (line_last)
                    begin
                        phase_next = PH_SEEK;
                        if (state_next == S_IDLE)
                            cmd.line_reset = 1'b1;
                        else
                            plan_reset_next = 1'b1;
                    end
                end
            end
            S_FL1:
            begin
                priority if (st.esc == ESC_IDLE)
                begin
                    cmd.esc_clear = 1'b1;
                    state_next    = flush_target;
                end
                else if (plan_key_reg || st.out_free)
                begin
                    cmd.key_put_pct = plan_key_reg;
                    cmd.out_load    = !plan_key_reg;
                    cmd.out_src     = SRC_PCT;
                    if (st.esc == ESC_DIGIT)
                        state_next = S_FL2;
                    else
                    begin
                        cmd.esc_clear = 1'b1;
                        state_next    = flush_target;
                    end
                end
            end
            S_FL2:
            begin
                if (plan_key_reg || st.out_free)
                begin
                    cmd.key_put_held = plan_key_reg;
                    cmd.out_load     = !plan_key_reg;
                    cmd.out_src      = SRC_HELD;
                    cmd.esc_clear    = 1'b1;
                    state_next       = flush_target;
                end
            end
            S_KRD:
            begin
                if (st.key_done)
                    state_next = S_KEND;
                else
                begin
                    cmd.key_rd = 1'b1;
                    state_next = S_KOUT;
                end
            end
            S_KOUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_src     = SRC_STORE;
                    cmd.key_idx_inc = 1'b1;
                    state_next      = S_KRD;
                end
            end
            S_KEND:
            begin
                if (st.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_src      = SRC_KEY_END;
                    cmd.out_run_last = !plan_pair_reg;
                    cmd.esc_clear    = 1'b1;
                    if (plan_pair_reg)
                        state_next = S_PEND;
                    else
                        seq_done = 1'b1;
                end
            end
            S_VAL:
            begin
                if (st.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_src      = SRC_VALUE;
                    cmd.out_run_last = !plan_pair_reg;
                    if (plan_pair_reg)
                        state_next = S_FL1;
                    else
                        seq_done = 1'b1;
                end
            end
            S_PEND:
            begin
                if (st.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_src      = SRC_PAIR_END;
                    cmd.out_run_last = 1'b1;
                    cmd.pair_inc     = 1'b1;
                    cmd.clear_key    = 1'b1;
                    seq_done         = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (seq_done)
        begin
            state_next     = S_IDLE;
            cmd.line_reset = plan_reset_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEEK;
            state_reg      <= S_IDLE;
            plan_key_reg   <= 1'b0;
            plan_pair_reg  <= 1'b0;
            plan_reset_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            state_reg      <= state_next;
            plan_key_reg   <= plan_key_next;
            plan_pair_reg  <= plan_pair_next;
            plan_reset_reg <= plan_reset_next;
        end
    end

endmodule

### design/query_string_pair_splitter.sv
// Query string pair splitter. Feed an HTTP request line one byte per word on
// the line channel, with line_last set on its final byte; the block skips up
// to the first space, then prefix_skip more bytes (sampled when that space
// arrives; written through the cfg channel, reset value 2), and treats what
// follows up to the next space or the line end as the query body. The body is
// split on '&'; segments without '=' are dropped. Each pair comes out on the
// token channel as the decoded key bytes, a key end (key_truncated set if the
// key ran past KEY_MAX bytes), the decoded value bytes and a pair end, all
// tagged with a pair index that saturates at 255; run_last marks the final
// token caused by one line word. '+' decodes to a space and "%xy" as a hex
// escape; a short escape stays literal. A line word that yields a value byte
// holds the line channel while that token is loaded; the '=' that closes a key
// holds it for an escape flush, then per buffered key byte one key buffer read,
// registered, then the output load, a step to find the end of the buffer, the
// key end and a pair end when the line ends there; a body end in a value adds
// an escape flush and a pair end. Token stalls add to all of these. The
// controller walks one word at a time; the token register lets the next word
// enter while a token waits.
module query_string_pair_splitter
    import qsps_pkg::*;
#(
    parameter int KEY_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // line channel: one request line byte per word
    input  logic        line_valid,
    output logic        line_stall,
    input  line_word_t  line_data,
    // token channel: one key/value token per word
    output logic        tok_valid,
    input  logic        tok_stall,
    output token_word_t tok_data,
    // prefix_skip register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);

    qsps_cmd_t    cmd;
    qsps_status_t st;

    // The user must land config writes only while idle (not enforced); take them at once
    assign cfg_ready = 1'b1;

    // Controller: line phase plus the burst sequencer that orders the tokens
    // caused by one word (key flush, key bytes, key end, value byte, value
    // flush, pair end)
    qsps_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (line_valid),
        .line_last  (line_data.line_last),
        .line_stall (line_stall),
        .st         (st),
        .cmd        (cmd)
    );

    // Datapath: escape decoder, key buffer memory, counters and the token
    // output register
    qsps_datapath #(
        .KEY_MAX (KEY_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_data (line_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

endmodule
